// ===== hdl/general_matrix_multiply_assert.svh =====
// ----------------------------------------------------------------------------
// gemm assertion macros
// Small wrappers for concurrent checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef GENERAL_MATRIX_MULTIPLY_ASSERT_SVH
`define GENERAL_MATRIX_MULTIPLY_ASSERT_SVH

// implication checked every cycle out of reset
`define GEMM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GEMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gemm_pkg.sv =====
// ----------------------------------------------------------------------------
// gemm_pkg
// Shared types and constants of the matrix multiply block.
// ----------------------------------------------------------------------------
package gemm_pkg;
	localparam int MaxDim   = 8;
	localparam int Depth    = MaxDim * MaxDim;
	localparam int IdxW     = $clog2(Depth);
	localparam int DimW     = 4;
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_LOAD_C = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ROWS  = 3'd0,
		REG_COLS  = 3'd1,
		REG_INNER = 3'd2,
		REG_ALPHA = 3'd3,
		REG_BETA  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		op_t               op;
		logic [IdxW-1:0]   idx;
		logic signed [31:0] val;
	} req_t;

	typedef struct packed {
		logic          q_empty;
		logic          busy;
	} back_stat_t;

	function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
		eff_dim = (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
		if (x > 72'sd2147483647) sat32 = 32'sh7fffffff;
		else if (x < -72'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = x[31:0];
	endfunction
endpackage

// ===== hdl/gemm_front.sv =====
// ----------------------------------------------------------------------------
// gemm_front
// Accepts requests, drops them while the queue is full, queues the rest for the back.
// ----------------------------------------------------------------------------
module gemm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           operation,
	input  logic [gemm_pkg::IdxW-1:0] elem_index,
	input  logic signed [31:0]   elem_value,
	input  logic                 pop,
	output gemm_pkg::req_t       head,
	output logic                 q_empty,
	output logic                 q_full
);
	import gemm_pkg::*;

	req_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QPtrW:0]   cnt_q;
	logic             push;

	assign q_full  = (cnt_q == (QPtrW+1)'(QDepth));
	assign q_empty = (cnt_q == '0);
	assign push    = start && !q_full;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{op: op_t'(operation), idx: elem_index, val: elem_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
		end
	end
endmodule

// ===== hdl/gemm_back.sv =====
// ----------------------------------------------------------------------------
// gemm_back
// Element stores and a shared multiply-accumulate sequencer for runs.
// ----------------------------------------------------------------------------
module gemm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gemm_pkg::req_t       head,
	input  logic                 q_empty,
	output logic                 pop,
	input  logic [gemm_pkg::DimW-1:0] dim_m,
	input  logic [gemm_pkg::DimW-1:0] dim_n,
	input  logic [gemm_pkg::DimW-1:0] dim_k,
	input  logic signed [31:0]   alpha,
	input  logic signed [31:0]   beta,
	output logic                 res_vld,
	output logic [gemm_pkg::IdxW-1:0] res_idx,
	output logic signed [31:0]   res_val,
	output logic                 res_last,
	output gemm_pkg::back_stat_t stat
);
	import gemm_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_MAC   = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_ADD   = 7'b0100000,
		ST_WB    = 7'b1000000
	} st_t;

	st_t st_q;
	logic signed [31:0] mem_a [Depth];
	logic signed [31:0] mem_b [Depth];
	logic signed [31:0] mem_c [Depth];
	logic signed [31:0] a_rd_q, b_rd_q, c_rd_q;
	logic [IdxW-1:0]  clr_q;
	logic [DimW-1:0]  m_q, n_q, k_q;
	logic [2:0]       i_q, j_q, kk_q;
	logic             rd_vld_q, rd_last_q;
	logic             mac_vld_q, mac_last_q;
	logic signed [63:0] prod_q;
	logic signed [71:0] acc_q;
	logic signed [31:0] s_q;
	logic signed [63:0] pa_q, pb_q;
	logic signed [31:0] nv;
	logic [IdxW-1:0]  a_addr, b_addr, c_addr;
	logic             load_go, run_go;

	assign load_go = (st_q == ST_IDLE) && !q_empty && (head.op != OP_RUN);
	assign run_go  = (st_q == ST_IDLE) && !q_empty && (head.op == OP_RUN);
	assign pop     = load_go || run_go;
	assign stat    = '{q_empty: q_empty, busy: (st_q != ST_IDLE)};

	assign a_addr = IdxW'(i_q) * IdxW'(k_q) + IdxW'(kk_q);
	assign b_addr = IdxW'(kk_q) * IdxW'(n_q) + IdxW'(j_q);
	assign c_addr = IdxW'(i_q) * IdxW'(n_q) + IdxW'(j_q);
	// arithmetic shift floors the result; the sum is exact in 72 bits
	assign nv = sat32((72'(pa_q) + 72'(pb_q)) >>> 16);

	always_ff @(posedge clk) begin
		if (load_go && head.op == OP_LOAD_A) mem_a[head.idx] <= head.val;
		if (load_go && head.op == OP_LOAD_B) mem_b[head.idx] <= head.val;
		if (st_q == ST_CLEAR) mem_c[clr_q] <= '0;
		else if (load_go && head.op == OP_LOAD_C) mem_c[head.idx] <= head.val;
		else if (st_q == ST_WB) mem_c[c_addr] <= nv;
		a_rd_q <= mem_a[a_addr];
		b_rd_q <= mem_b[b_addr];
		c_rd_q <= mem_c[c_addr];
		prod_q <= 64'(a_rd_q) * 64'(b_rd_q);
		pa_q   <= 64'(alpha) * 64'(s_q);
		pb_q   <= 64'(beta) * 64'(c_rd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			{m_q, n_q, k_q} <= '0;
			{i_q, j_q, kk_q} <= '0;
			{rd_vld_q, rd_last_q} <= '0;
			{mac_vld_q, mac_last_q} <= '0;
			acc_q <= '0;
			s_q <= '0;
			res_vld <= 1'b0;
			res_idx <= '0;
			res_val <= '0;
			res_last <= 1'b0;
		end else begin
			// product of an address pair is valid in prod_q after the read registers; mac_vld_q marks it
			rd_vld_q   <= (st_q == ST_RD);
			rd_last_q  <= (st_q == ST_RD) && (DimW'(kk_q) + 1'b1 == k_q);
			mac_vld_q  <= rd_vld_q;
			mac_last_q <= rd_last_q;
			res_vld    <= (st_q == ST_WB);
			res_last   <= (st_q == ST_WB) && (DimW'(i_q) + 1'b1 == m_q) &&
				(DimW'(j_q) + 1'b1 == n_q);
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IdxW'(Depth-1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (run_go) begin
						m_q <= eff_dim(dim_m);
						n_q <= eff_dim(dim_n);
						k_q <= eff_dim(dim_k);
						{i_q, j_q, kk_q} <= '0;
						acc_q <= '0;
						if (dim_m != '0 && dim_n != '0 && dim_k != '0) st_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (mac_vld_q) acc_q <= acc_q + 72'(prod_q);
					if (DimW'(kk_q) + 1'b1 == k_q) st_q <= ST_MAC;
					else kk_q <= kk_q + 1'b1;
				end
				ST_MAC: begin
					if (mac_vld_q) acc_q <= acc_q + 72'(prod_q);
					if (mac_last_q) begin
						s_q <= sat32((acc_q + 72'(prod_q)) >>> 16);
						st_q <= ST_SCALE;
					end
				end
				ST_SCALE: st_q <= ST_ADD;
				ST_ADD:   st_q <= ST_WB;
				ST_WB: begin
					res_idx  <= c_addr;
					res_val  <= nv;
					kk_q <= '0;
					acc_q <= '0;
					if (DimW'(j_q) + 1'b1 == n_q) begin
						j_q <= '0;
						if (DimW'(i_q) + 1'b1 == m_q) st_q <= ST_IDLE;
						else begin
							i_q <= i_q + 1'b1;
							st_q <= ST_RD;
						end
					end else begin
						j_q <= j_q + 1'b1;
						st_q <= ST_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/general_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// general_matrix_multiply
// C = alpha*(A x B) + beta*C on row-major Q16.16 matrices up to 8x8.
// ----------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// request  | in  | start && !busy       | operation, elem_index, elem_value
// result   | out | done strobe, 1 cycle | out_index, out_value, last_entry
// config   | in  | cfg_we               | cfg_index, cfg_data
//
// Loads retire from a 4-entry queue whenever the sequencer is idle. A run
// computes one C entry at a time on the single multiply-accumulate unit:
// read, accumulate, scale, add and write back. After reset a pass clears
// all 64 entries of the C store; requests queue up meanwhile. busy reflects
// a full request queue; results cannot be stalled.
// ----------------------------------------------------------------------------
module general_matrix_multiply (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [5:0]  elem_index,
	input  logic signed [31:0] elem_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [5:0]  out_index,
	output logic signed [31:0] out_value,
	output logic        last_entry
);
	import gemm_pkg::*;
	`include "general_matrix_multiply_assert.svh"

	logic [DimW-1:0] m_q, n_q, k_q;
	logic signed [31:0] alpha_q, beta_q;
	req_t head;
	logic q_empty, q_full, pop;
	back_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= DimW'(8);
			n_q <= DimW'(8);
			k_q <= DimW'(8);
			alpha_q <= 32'sd65536;
			beta_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROWS:  m_q <= cfg_data[DimW-1:0];
				REG_COLS:  n_q <= cfg_data[DimW-1:0];
				REG_INNER: k_q <= cfg_data[DimW-1:0];
				REG_ALPHA: alpha_q <= cfg_data;
				REG_BETA:  beta_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = q_full;

	gemm_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.elem_index(elem_index), .elem_value(elem_value), .pop(pop),
		.head(head), .q_empty(q_empty), .q_full(q_full)
	);

	gemm_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .pop(pop),
		.dim_m(m_q), .dim_n(n_q), .dim_k(k_q), .alpha(alpha_q), .beta(beta_q),
		.res_vld(done), .res_idx(out_index), .res_val(out_value),
		.res_last(last_entry), .stat(stat)
	);

	`GEMM_ASSERT_IMP(a_pop_nonempty, pop, !q_empty, "pop from empty queue")
	`GEMM_ASSERT_IMP(a_last_done, last_entry, done, "last flag without strobe")
	`GEMM_ASSERT_NEXT(a_done_gap, done, !done, "results back to back")
	`GEMM_ASSERT_IMP(a_pop_idle, pop, !stat.busy && !stat.q_empty, "pop while busy")
endmodule
